// ===== src/ubri_pkg.sv =====
// Shared types and constants for the bias-free bounded random integer mapper.
// Holds word widths, register indexes and the setup bundle passed to the datapath.
// No dependencies.
package ubri_pkg;

    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CNT_W       = $clog2(WORD_W);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER = CFG_INDEX_W'(1);

    // Derived range settings, valid while ready is high
    typedef struct packed {
        logic              ready;
        logic              range_zero;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] range;
        logic [WORD_W-1:0] thr;
    } setup_t;

endpackage

// ===== src/ubri_setup.sv =====
// Bound registers, bound ordering and the iterative remainder unit for the threshold.
// Produces the setup bundle consumed by ubri_pipe.
// Depends on ubri_pkg.
module ubri_setup (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ubri_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ubri_pkg::WORD_W-1:0]        cfg_data,
    output ubri_pkg::setup_t                   setup
);

    typedef enum logic [3:0] {
        ST_PREP  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_READY = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ubri_pkg::WORD_W-1:0]     lower_reg, lower_next;
    logic [ubri_pkg::WORD_W-1:0]     upper_reg, upper_next;
    logic [ubri_pkg::WORD_W-1:0]     lo_reg, lo_next;
    logic [ubri_pkg::WORD_W-1:0]     range_reg, range_next;
    logic                            zero_reg, zero_next;
    logic [ubri_pkg::WORD_W-1:0]     quo_reg, quo_next;
    logic [ubri_pkg::WORD_W-1:0]     rem_reg, rem_next;
    logic [ubri_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ubri_pkg::WORD_W:0]       trial;
    logic                            swap;

    assign swap  = $signed(lower_reg) > $signed(upper_reg);
    assign trial = {rem_reg, quo_reg[ubri_pkg::WORD_W-1]};

    always_comb
    begin
        state_next = state_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        lo_next    = lo_reg;
        range_next = range_reg;
        zero_next  = zero_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_PREP:
            begin
                // order the bounds and form the span
                if (swap)
                begin
                    lo_next    = upper_reg;
                    range_next = lower_reg - upper_reg + ubri_pkg::WORD_W'(1);
                end
                else
                begin
                    lo_next    = lower_reg;
                    range_next = upper_reg - lower_reg + ubri_pkg::WORD_W'(1);
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                zero_next = (range_reg == '0);
                quo_next  = '0 - range_reg;
                rem_next  = '0;
                cnt_next  = ubri_pkg::CNT_W'(ubri_pkg::WORD_W - 1);
                // a full span never rejects, so skip the remainder
                state_next = (range_reg == '0) ? ST_READY : ST_DIV;
            end
            ST_DIV:
            begin
                // one restoring step per cycle
                if (trial >= {1'b0, range_reg})
                begin
                    rem_next = ubri_pkg::WORD_W'(trial - {1'b0, range_reg});
                end
                else
                begin
                    rem_next = trial[ubri_pkg::WORD_W-1:0];
                end
                quo_next = {quo_reg[ubri_pkg::WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg - ubri_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_READY;
                end
            end
            ST_READY:
            begin
                state_next = ST_READY;
            end
            default:
            begin
                state_next = ST_PREP;
            end
        endcase
        // a write restarts the derivation
        if (cfg_write)
        begin
            if (cfg_index == ubri_pkg::REG_LOWER)
            begin
                lower_next = cfg_data;
                state_next = ST_PREP;
            end
            else if (cfg_index == ubri_pkg::REG_UPPER)
            begin
                upper_next = cfg_data;
                state_next = ST_PREP;
            end
        end
    end

    // reset leaves bounds at zero: span one, threshold zero, ready at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READY;
            lower_reg <= '0;
            upper_reg <= '0;
            lo_reg    <= '0;
            range_reg <= ubri_pkg::WORD_W'(1);
            zero_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            lo_reg    <= lo_next;
            range_reg <= range_next;
            zero_reg  <= zero_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign setup.ready      = (state_reg == ST_READY);
    assign setup.range_zero = zero_reg;
    assign setup.lo         = lo_reg;
    assign setup.range      = range_reg;
    assign setup.thr        = rem_reg;

`ifndef SYNTHESIS
    a_thr_below_range: assert property (@(posedge clk) disable iff (!rst_n)
        setup.ready && !setup.range_zero |-> setup.thr < setup.range)
        else $error("threshold not below range");
    a_ready_drop_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(setup.ready) |-> $past(cfg_write))
        else $error("setup left ready without a register write");
`endif

endmodule

// ===== src/ubri_pipe.sv =====
// Three-stage datapath: capture word, multiply by range, judge and offset.
// Uses the setup bundle from ubri_setup.
// Depends on ubri_pkg.
module ubri_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ubri_pkg::setup_t              setup,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ubri_pkg::WORD_W-1:0]   random_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ubri_pkg::WORD_W-1:0] bounded_value
);

    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                          s1_valid_next, s2_valid_next, s3_valid_next;
    logic [ubri_pkg::WORD_W-1:0]   s1_word_reg, s2_word_reg;
    logic [ubri_pkg::PROD_W-1:0]   s2_prod_reg, s2_prod_next;
    logic [ubri_pkg::WORD_W-1:0]   s3_value_reg, s3_value_next;
    logic                          en1, en2, en3;
    logic                          keep;
    logic [ubri_pkg::WORD_W-1:0]   offset;

    // advance a stage when it is empty or its successor advances
    assign en3 = !s3_valid_reg || !out_stall;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign in_stall = !en1 || !setup.ready;

    assign s1_valid_next = in_valid && setup.ready;
    assign s2_valid_next = s1_valid_reg;
    assign s2_prod_next  = ubri_pkg::PROD_W'(s1_word_reg) * ubri_pkg::PROD_W'(setup.range);

    // drop words whose product's low half falls below the threshold, unless the span is full
    assign keep = setup.range_zero
                  || (s2_prod_reg[ubri_pkg::WORD_W-1:0] >= setup.thr);
    assign offset = setup.range_zero ? s2_word_reg
                                     : s2_prod_reg[ubri_pkg::PROD_W-1:ubri_pkg::WORD_W];
    assign s3_valid_next = s2_valid_reg && keep;
    assign s3_value_next = setup.lo + offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (en2)
            begin
                s2_valid_reg <= s2_valid_next;
            end
            if (en3)
            begin
                s3_valid_reg <= s3_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_word_reg <= random_word;
        end
        if (en2)
        begin
            s2_word_reg <= s1_word_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (en3)
        begin
            s3_value_reg <= s3_value_next;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign bounded_value = $signed(s3_value_reg);

`ifndef SYNTHESIS
    a_accept_needs_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> setup.ready)
        else $error("transaction accepted before setup was ready");
    a_value_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && setup.ready && !setup.range_zero
            |-> (s3_value_reg - setup.lo) < setup.range)
        else $error("result outside configured bounds");
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !en2 |=> $stable(s2_prod_reg))
        else $error("stalled product stage changed");
`endif

endmodule

// ===== src/unbiased_bounded_random_integer.sv =====
// Top level of the bias-free bounded random integer mapper.
// Instantiates ubri_setup (bounds and threshold) and ubri_pipe (datapath).
// Depends on ubri_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / random_word) carries one uniform
//   32-bit word per transaction. Output channel (out_valid / out_stall /
//   bounded_value) carries one signed value inside the inclusive bounds.
//   Rejected words produce no output transaction.
//   Configuration: cfg_write with cfg_index 0 writes the lower bound, index 1
//   the upper bound; other indexes are ignored. Reversed bounds are swapped.
//   Write only while no transaction is in flight.
// Timing:
//   One word per cycle sustained while setup is ready and the receiver does not
//   stall. Each word passes the three-stage pipeline (capture, 32x32 multiply,
//   compare and offset) before its result is presented.
//   After a register write, in_stall stays high while the bounds are ordered and
//   the threshold (-range mod range) is formed one bit per cycle by the
//   restoring remainder unit; a full 32-bit span skips that unit.
// Reset: bounds return to zero, so every word maps to zero; the block is
//   ready at once. When the receiver stalls, results hold and the pipeline
//   keeps filling its empty stages before in_stall rises.
module unbiased_bounded_random_integer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ubri_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ubri_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ubri_pkg::WORD_W-1:0]         random_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ubri_pkg::WORD_W-1:0]  bounded_value
);

    ubri_pkg::setup_t setup;

    // bounds, ordering and threshold
    ubri_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .setup     (setup)
    );

    // multiply, judge and offset each word
    ubri_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .setup         (setup),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .random_word   (random_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bounded_value (bounded_value)
    );

endmodule
